FILE: rtl/fiber_conductivity_tensor_assert.svh
// Assertion macros for the fiber conductivity tensor block.
// Included by the top level; depends on nothing else.
`ifndef FIBER_CONDUCTIVITY_TENSOR_ASSERT_SVH
`define FIBER_CONDUCTIVITY_TENSOR_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define FCT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: rtl/fct_pkg.sv
// Package for the fiber conductivity tensor block: constants, CORDIC table and
// register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fct_pkg;
	localparam int COORD_BITS_DEF = 12;
	localparam int TRIG_FRAC_BITS_DEF = 16;
	localparam int CORDIC_STEPS = 23;
	localparam int ANG_W = 48;
	localparam logic signed [ANG_W-1:0] FULL_TURN = 48'sd23592960;
	localparam logic signed [ANG_W-1:0] HALF_TURN = 48'sd11796480;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 48'sd5898240;
	localparam logic signed [ANG_W-1:0] FIBER_BASE = 48'sd3932160;
	localparam logic signed [ANG_W-1:0] FIBER_CONST = -48'sd3932160;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
	localparam int CFG_W = 31;
	localparam int IDX_W = 3;
	typedef enum logic [IDX_W-1:0] {
		REG_HOMOGENEOUS = 3'd0,
		REG_ROT_MODE = 3'd1,
		REG_SIGMA_L = 3'd2,
		REG_SIGMA_T = 3'd3,
		REG_SHEET = 3'd4,
		REG_TWIST = 3'd5,
		REG_THRESH = 3'd6
	} reg_idx_t;
	typedef logic signed [ANG_W-1:0] angle_t;
	function automatic logic signed [23:0] atan_q16(input int i);
		logic signed [23:0] t;
		case (i)
			0: t = 24'sd2949120; 1: t = 24'sd1740967; 2: t = 24'sd919879;
			3: t = 24'sd466945; 4: t = 24'sd234379; 5: t = 24'sd117304;
			6: t = 24'sd58666; 7: t = 24'sd29335; 8: t = 24'sd14668;
			9: t = 24'sd7334; 10: t = 24'sd3667; 11: t = 24'sd1833;
			12: t = 24'sd917; 13: t = 24'sd458; 14: t = 24'sd229;
			15: t = 24'sd115; 16: t = 24'sd57; 17: t = 24'sd29;
			18: t = 24'sd14; 19: t = 24'sd7; 20: t = 24'sd4;
			21: t = 24'sd2; 22: t = 24'sd1;
			default: t = 24'sd0;
		endcase
		return t;
	endfunction
endpackage
`default_nettype wire

FILE: rtl/fct_angle_reduce.sv
// Reduces a Q16.16 degree angle into [-90,90] plus a negate flag, pipelined.
// Depends on fct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fct_angle_reduce (
	input wire logic clk,
	input wire logic en,
	input wire fct_pkg::angle_t ang,
	output fct_pkg::angle_t red,
	output logic neg
);
	import fct_pkg::*;
	// A 48-bit angle is at most about 2^23 turns; take out whole turns in
	// two steps: a coarse reciprocal estimate then a small correction.
	localparam int RECIP_SH = 48;
	localparam logic [25:0] RECIP = 26'(((64'd1 << RECIP_SH) + 64'd23592959) / 64'd23592960);
	logic [ANG_W-1:0] mag_s1;
	logic sgn_s1;
	angle_t ang_s1;
	logic [23:0] quo_s2;
	angle_t ang_s2;
	logic sgn_s2;
	angle_t rem_s3;
	logic [ANG_W+25:0] prod;
	angle_t rem_c, r0, r1;

	always_ff @(posedge clk) begin
		if (en) begin
			sgn_s1 <= ang[ANG_W-1];
			mag_s1 <= ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
			ang_s1 <= ang;
		end
	end
	assign prod = {26'd0, mag_s1} * {{ANG_W{1'b0}}, RECIP};
	always_ff @(posedge clk) begin
		if (en) begin
			quo_s2 <= prod[RECIP_SH +: 24];
			ang_s2 <= ang_s1;
			sgn_s2 <= sgn_s1;
		end
	end
	// Quotient estimate may be off by one; remainder computed on the signed
	// angle then brought into [0,360) with a compare either side.
	always_comb begin
		rem_c = sgn_s2 ? angle_t'(ang_s2 + angle_t'({24'd0, quo_s2}) * FULL_TURN)
			: angle_t'(ang_s2 - angle_t'({24'd0, quo_s2}) * FULL_TURN);
		if (rem_c < 0) rem_c = rem_c + FULL_TURN;
		if (rem_c >= FULL_TURN) rem_c = rem_c - FULL_TURN;
	end
	always_ff @(posedge clk) begin
		if (en) rem_s3 <= rem_c;
	end
	always_comb begin
		r0 = rem_s3;
		if (r0 > HALF_TURN) r0 = r0 - FULL_TURN;
		r1 = r0;
		if (r0 > QUARTER_TURN) r1 = r0 - HALF_TURN;
		else if (r0 < -QUARTER_TURN) r1 = r0 + HALF_TURN;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			red <= r1;
			neg <= (r0 > QUARTER_TURN) || (r0 < -QUARTER_TURN);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/fct_cordic.sv
// Pipelined CORDIC in Q30, one stage per iteration, rounding to Q.T output.
// Depends on fct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fct_cordic #(
	parameter int TRIG_FRAC_BITS = fct_pkg::TRIG_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic en,
	input wire fct_pkg::angle_t ang,
	input wire logic neg,
	output logic signed [TRIG_FRAC_BITS+1:0] sn,
	output logic signed [TRIG_FRAC_BITS+1:0] cs
);
	import fct_pkg::*;
	localparam int SH = 30 - TRIG_FRAC_BITS;
	logic signed [33:0] x_q [CORDIC_STEPS+1];
	logic signed [33:0] y_q [CORDIC_STEPS+1];
	logic signed [25:0] z_q [CORDIC_STEPS+1];
	logic neg_q [CORDIC_STEPS+1];
	logic signed [33:0] xr, yr;

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= CORDIC_GAIN_Q30;
			y_q[0] <= '0;
			z_q[0] <= 26'(ang);
			neg_q[0] <= neg;
		end
	end
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_q[i][25]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - 26'(atan_q16(i));
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + 26'(atan_q16(i));
				end
				neg_q[i+1] <= neg_q[i];
			end
		end
	end
	assign xr = (x_q[CORDIC_STEPS] + (34'sd1 <<< (SH - 1))) >>> SH;
	assign yr = (y_q[CORDIC_STEPS] + (34'sd1 <<< (SH - 1))) >>> SH;
	always_ff @(posedge clk) begin
		if (en) begin
			cs <= neg_q[CORDIC_STEPS] ? (TRIG_FRAC_BITS+2)'(-xr) : (TRIG_FRAC_BITS+2)'(xr);
			sn <= neg_q[CORDIC_STEPS] ? (TRIG_FRAC_BITS+2)'(-yr) : (TRIG_FRAC_BITS+2)'(yr);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/fct_tensor.sv
// Builds rotation columns and the weighted tensor entries with rounding,
// saturation and thresholding. Depends on fct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fct_tensor #(
	parameter int TRIG_FRAC_BITS = fct_pkg::TRIG_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic en,
	input wire logic mode,
	input wire logic [30:0] gl,
	input wire logic [30:0] gt,
	input wire logic [15:0] thresh,
	input wire logic signed [TRIG_FRAC_BITS+1:0] sf,
	input wire logic signed [TRIG_FRAC_BITS+1:0] cf,
	input wire logic signed [TRIG_FRAC_BITS+1:0] ss,
	input wire logic signed [TRIG_FRAC_BITS+1:0] cs,
	output logic [5:0][31:0] d
);
	import fct_pkg::*;
	localparam int T = TRIG_FRAC_BITS;
	localparam int EW = T + 3;
	localparam int PW = 2 * EW;
	localparam int AW = 36 + 2 * EW;
	typedef logic signed [EW-1:0] e_t;
	e_t e1_s1 [3], e2_s1 [3], e3_s1 [3];
	e_t p_s2 [6][3];
	logic signed [AW-1:0] a_s3 [6][3];
	logic signed [AW-1:0] sum_s4 [6];
	logic [30:0] gl_s1, gt_s1, gl_s2, gt_s2;
	logic [15:0] th_s1, th_s2, th_s3, th_s4;

	function automatic e_t mulq(input logic signed [T+1:0] a, input logic signed [T+1:0] b);
		logic signed [2*T+3:0] p;
		p = a * b + ((2*T+4)'(1) <<< (T - 1));
		return e_t'(p >>> T);
	endfunction
	function automatic e_t rnd(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] q;
		q = p + (PW'(1) <<< (T - 1));
		return e_t'(q >>> T);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1[0] <= e_t'(cf);
			e1_s1[1] <= '0;
			e2_s1[1] <= e_t'(cs);
			e2_s1[2] <= mulq(cf, ss);
			if (!mode) begin
				e1_s1[2] <= e_t'(sf);
				e2_s1[0] <= -mulq(sf, ss);
				e3_s1[0] <= mulq(sf, cs);
				e3_s1[1] <= e_t'(ss);
				e3_s1[2] <= -mulq(cf, cs);
			end else begin
				e1_s1[2] <= -e_t'(sf);
				e2_s1[0] <= mulq(sf, ss);
				e3_s1[0] <= mulq(sf, cs);
				e3_s1[1] <= -e_t'(ss);
				e3_s1[2] <= mulq(cf, cs);
			end
			gl_s1 <= gl;
			gt_s1 <= gt;
			th_s1 <= thresh;
		end
	end
	localparam int II [6] = '{0, 0, 0, 1, 1, 2};
	localparam int JJ [6] = '{0, 1, 2, 1, 2, 2};
	for (genvar k = 0; k < 6; k++) begin : g_ent
		logic signed [AW-1:0] sat_c;
		logic signed [31:0] dv;
		logic signed [AW-1:0] r;
		always_ff @(posedge clk) begin
			if (en) begin
				p_s2[k][0] <= rnd(PW'(e1_s1[II[k]]) * PW'(e1_s1[JJ[k]]));
				p_s2[k][1] <= rnd(PW'(e2_s1[II[k]]) * PW'(e2_s1[JJ[k]]));
				p_s2[k][2] <= rnd(PW'(e3_s1[II[k]]) * PW'(e3_s1[JJ[k]]));
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				a_s3[k][0] <= AW'($signed({1'b0, gl_s2})) * AW'(p_s2[k][0]);
				a_s3[k][1] <= AW'($signed({1'b0, gt_s2})) * AW'(p_s2[k][1]);
				a_s3[k][2] <= AW'($signed({1'b0, gt_s2})) * AW'(p_s2[k][2]);
			end
		end
		always_ff @(posedge clk) begin
			if (en) sum_s4[k] <= a_s3[k][0] + a_s3[k][1] + a_s3[k][2];
		end
		always_comb begin
			r = (sum_s4[k] + (AW'(1) <<< (T - 1))) >>> T;
			if (r > AW'(64'sh7FFFFFFF)) sat_c = AW'(64'sh7FFFFFFF);
			else if (r < -AW'(64'sh80000000)) sat_c = -AW'(64'sh80000000);
			else sat_c = r;
			dv = 32'(sat_c);
			if ((sat_c < 0 ? -sat_c : sat_c) < AW'({1'b0, th_s4})) dv = '0;
		end
		always_ff @(posedge clk) begin
			if (en) d[k] <= dv;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			gl_s2 <= gl_s1;
			gt_s2 <= gt_s1;
			th_s2 <= th_s1;
			th_s3 <= th_s2;
			th_s4 <= th_s3;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/fiber_conductivity_tensor.sv
// Fiber conductivity tensor block. One cell coordinate enters per cycle while
// in_stall is low, and the six tensor entries come out at the end of the
// pipeline: the angle reduction, the CORDIC pipeline and the tensor multiply
// stages, 35 register stages in all. The whole pipeline advances unless a
// valid output is stalled, so a stalled request waits in place and nothing
// is lost. Depends on fct_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fiber_conductivity_tensor #(
	parameter int COORD_BITS = fct_pkg::COORD_BITS_DEF,
	parameter int TRIG_FRAC_BITS = fct_pkg::TRIG_FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [fct_pkg::IDX_W-1:0] cfg_index,
	input wire logic [fct_pkg::CFG_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [COORD_BITS-1:0] transmural_index,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] d_xx,
	output logic signed [31:0] d_xy,
	output logic signed [31:0] d_xz,
	output logic signed [31:0] d_yy,
	output logic signed [31:0] d_yz,
	output logic signed [31:0] d_zz
);
	import fct_pkg::*;
	`include "fiber_conductivity_tensor_assert.svh"
	localparam int LAT = 1 + 4 + 1 + CORDIC_STEPS + 1 + 4 + 1;
	logic homog_q, mode_q;
	logic [30:0] gl_q, gt_q;
	logic signed [24:0] sheet_q;
	logic [22:0] twist_q;
	logic [15:0] thresh_q;
	logic en;
	logic [LAT-1:0] vld_q;
	angle_t fib_s1, fred, sred;
	logic fneg, sneg;
	logic signed [TRIG_FRAC_BITS+1:0] sf, cf, ss, cs;
	logic [5:0][31:0] d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			homog_q <= 1'b0;
			mode_q <= 1'b0;
			gl_q <= 31'd65536;
			gt_q <= 31'd65536;
			sheet_q <= '0;
			twist_q <= 23'd65536;
			thresh_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HOMOGENEOUS: homog_q <= cfg_data[0];
				REG_ROT_MODE: mode_q <= cfg_data[0];
				REG_SIGMA_L: gl_q <= cfg_data;
				REG_SIGMA_T: gt_q <= cfg_data;
				REG_SHEET: sheet_q <= cfg_data[24:0];
				REG_TWIST: twist_q <= cfg_data[22:0];
				REG_THRESH: thresh_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
	end
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (homog_q) fib_s1 <= FIBER_CONST;
			else fib_s1 <= FIBER_BASE - angle_t'($signed({1'b0, twist_q}))
				* angle_t'($signed({1'b0, 17'(transmural_index) + 17'd1}));
		end
	end

	fct_angle_reduce u_fred (.clk, .en, .ang(fib_s1), .red(fred), .neg(fneg));
	fct_angle_reduce u_sred (.clk, .en, .ang(angle_t'(sheet_q)), .red(sred),
		.neg(sneg));
	fct_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_fcor (.clk, .en, .ang(fred),
		.neg(fneg), .sn(sf), .cs(cf));
	fct_cordic #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_scor (.clk, .en, .ang(sred),
		.neg(sneg), .sn(ss), .cs(cs));
	fct_tensor #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_ten (.clk, .en, .mode(mode_q),
		.gl(gl_q), .gt(gt_q), .thresh(thresh_q), .sf, .cf, .ss, .cs, .d);

	assign d_xx = d[0];
	assign d_xy = d[1];
	assign d_xz = d[2];
	assign d_yy = d[3];
	assign d_yz = d[4];
	assign d_zz = d[5];

	`FCT_ASSERT_NEXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(d_xx))
	`FCT_ASSERT_IMP(a_in_stall_tracks, 1'b1, in_stall == (out_valid && out_stall))
	`FCT_ASSERT_NEXT(a_flow, en && in_valid, vld_q[0])
endmodule
`default_nettype wire
